// ===== hw/rtl/nmea_sc_pkg.sv =====
// ============================================================================
// NMEA sentence checker package
// Shared character codes, field widths, result and configuration types, and
// the hex digit decoder used by the character step logic.
// ============================================================================
`default_nettype none

package nmea_sc_pkg;

    // Field widths
    localparam int CHAR_W    = 8;
    localparam int FIELD_W   = 6;
    localparam int VERDICT_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int HEX_W     = 9;

    // Highest field index the counters reach; counts saturate here
    localparam int MAX_FIELDS = 63;
    localparam int SAT_LIMIT  = (MAX_FIELDS < 63) ? MAX_FIELDS : 63;
    localparam logic [FIELD_W-1:0] SAT_COUNT = FIELD_W'(SAT_LIMIT);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SELECTED_FIELD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_FIELD = 2'd1;

    // Verdict codes
    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_GOOD   = 2'd0,
        VERDICT_BAD    = 2'd1,
        VERDICT_ABSENT = 2'd2
    } t_verdict;

    // Configuration registers as seen by the step logic
    typedef struct packed {
        logic [FIELD_W-1:0] selected_field;
        logic [FIELD_W-1:0] checksum_field;
    } t_cfg;

    // One result beat
    typedef struct packed {
        logic               field_char_valid;
        logic [CHAR_W-1:0]  field_char;
        logic               done_res;
        logic [CHAR_W-1:0]  checksum;
        logic [FIELD_W-1:0] data_field_count;
        logic [VERDICT_W-1:0] verdict;
    } t_result;

    // Decoded hex digit: ok flags a digit, value holds its weight
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex_digit;

    function automatic t_hex_digit hex_digit(input logic [CHAR_W-1:0] c);
        t_hex_digit d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.value = 4'(c - 8'h57);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nmea_sc_if.sv =====
// ============================================================================
// NMEA sentence checker channels
// Valid/ready channels for sentence characters, result beats and
// configuration writes.
// ============================================================================
`default_nettype none

// Sentence character channel
interface nmea_char_if;
    import nmea_sc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              last;

    modport source (output valid, output char_in, output last, input ready);
    modport sink   (input valid, input char_in, input last, output ready);
endinterface

// Result channel
interface nmea_res_if;
    import nmea_sc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 field_char_valid;
    logic [CHAR_W-1:0]    field_char;
    logic                 done_res;
    logic [CHAR_W-1:0]    checksum;
    logic [FIELD_W-1:0]   data_field_count;
    logic [VERDICT_W-1:0] verdict;

    modport source (
        output valid, output field_char_valid, output field_char, output done_res,
        output checksum, output data_field_count, output verdict, input ready
    );
    modport sink (
        input valid, input field_char_valid, input field_char, input done_res,
        input checksum, input data_field_count, input verdict, output ready
    );
endinterface

// Configuration write channel
interface nmea_cfg_if;
    import nmea_sc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [FIELD_W-1:0]   wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nmea_sc_step.sv =====
// ============================================================================
// NMEA sentence checker step logic
// Holds the per-sentence state and works out one result beat per accepted
// character: XOR checksum, comma count, field streaming and hex parsing.
// ============================================================================
`default_nettype none

module nmea_sc_step (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [nmea_sc_pkg::CHAR_W-1:0] i_char_in,
    input  wire logic                          i_last,
    input  wire nmea_sc_pkg::t_cfg             i_cfg,
    output nmea_sc_pkg::t_result               o_result
);
    import nmea_sc_pkg::*;

    // Sentence state
    logic               r_at_start,    n_at_start;
    logic [CHAR_W-1:0]  r_xor_acc,     n_xor_acc;
    logic               r_xor_stopped, n_xor_stopped;
    logic [FIELD_W-1:0] r_sep_count,   n_sep_count;
    logic [FIELD_W-1:0] r_comma_count, n_comma_count;
    logic               r_star_seen,   n_star_seen;
    logic               r_sel_ended,   n_sel_ended;
    logic [1:0]         r_ck_len,      n_ck_len;
    logic               r_ck_ended,    n_ck_ended;
    logic [HEX_W-1:0]   r_hex_value,   n_hex_value;
    logic               r_hex_stopped, n_hex_stopped;

    logic               is_star;
    logic               is_sep;
    logic               is_end;
    logic               ck_take;
    t_hex_digit         digit;
    logic [CHAR_W+3:0]  hex_wide;

    // Per-character update
    always_comb begin
        n_at_start    = r_at_start;
        n_xor_acc     = r_xor_acc;
        n_xor_stopped = r_xor_stopped;
        n_sep_count   = r_sep_count;
        n_comma_count = r_comma_count;
        n_star_seen   = r_star_seen;
        n_sel_ended   = r_sel_ended;
        n_ck_len      = r_ck_len;
        n_ck_ended    = r_ck_ended;
        n_hex_value   = r_hex_value;
        n_hex_stopped = r_hex_stopped;

        is_star  = (i_char_in == CH_STAR);
        is_sep   = is_star || (i_char_in == CH_COMMA);
        is_end   = is_sep || (i_char_in == CH_NUL);
        ck_take  = 1'b0;
        digit    = hex_digit(i_char_in);
        hex_wide = {r_hex_value[CHAR_W-1:0], digit.value};

        o_result = '0;

        if (r_at_start) begin
            // skip the start mark
            n_at_start = 1'b0;
        end else begin
            // XOR up to the first star, CR or LF
            if (!r_xor_stopped) begin
                if (is_star || i_char_in == CH_CR || i_char_in == CH_LF) begin
                    n_xor_stopped = 1'b1;
                end else begin
                    n_xor_acc = r_xor_acc ^ i_char_in;
                end
            end

            // count commas before the first star
            if (!r_star_seen) begin
                if (is_star) begin
                    n_star_seen = 1'b1;
                end else if (i_char_in == CH_COMMA && r_comma_count < SAT_COUNT) begin
                    n_comma_count = r_comma_count + 1'b1;
                end
            end

            // stream the selected field
            if (!r_sel_ended && r_sep_count == i_cfg.selected_field) begin
                if (is_end) begin
                    n_sel_ended = 1'b1;
                end else begin
                    o_result.field_char_valid = 1'b1;
                    o_result.field_char       = i_char_in;
                end
            end

            // collect the checksum text
            if (!r_ck_ended) begin
                if (r_sep_count == i_cfg.checksum_field) begin
                    if (is_end) begin
                        n_ck_ended = 1'b1;
                    end else begin
                        ck_take = 1'b1;
                    end
                end else if (r_sep_count < i_cfg.checksum_field && is_star) begin
                    ck_take = 1'b1;
                end
            end

            // drop the first text character, parse hex digits after it
            if (ck_take) begin
                if (r_ck_len == 2'd0) begin
                    n_ck_len = 2'd1;
                end else begin
                    n_ck_len = 2'd2;
                    if (!r_hex_stopped) begin
                        if (!digit.ok) begin
                            n_hex_stopped = 1'b1;
                        end else if (r_hex_value[CHAR_W] || hex_wide[CHAR_W+3:CHAR_W] != 4'd0) begin
                            n_hex_value = {1'b1, hex_wide[CHAR_W-1:0]};
                        end else begin
                            n_hex_value = {1'b0, hex_wide[CHAR_W-1:0]};
                        end
                    end
                end
            end

            // advance the field index
            if (is_sep && r_sep_count < SAT_COUNT) begin
                n_sep_count = r_sep_count + 1'b1;
            end
        end

        // report on the last character, then clear the sentence state
        if (i_last) begin
            o_result.done_res         = 1'b1;
            o_result.checksum         = n_xor_acc;
            o_result.data_field_count = n_comma_count;
            if (n_ck_len == 2'd0) begin
                o_result.verdict = VERDICT_ABSENT;
            end else if (n_hex_value == {1'b0, n_xor_acc}) begin
                o_result.verdict = VERDICT_GOOD;
            end else begin
                o_result.verdict = VERDICT_BAD;
            end
            n_at_start    = 1'b1;
            n_xor_acc     = '0;
            n_xor_stopped = 1'b0;
            n_sep_count   = '0;
            n_comma_count = '0;
            n_star_seen   = 1'b0;
            n_sel_ended   = 1'b0;
            n_ck_len      = 2'd0;
            n_ck_ended    = 1'b0;
            n_hex_value   = '0;
            n_hex_stopped = 1'b0;
        end
    end

    // Update state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start    <= 1'b1;
            r_xor_acc     <= '0;
            r_xor_stopped <= 1'b0;
            r_sep_count   <= '0;
            r_comma_count <= '0;
            r_star_seen   <= 1'b0;
            r_sel_ended   <= 1'b0;
            r_ck_len      <= 2'd0;
            r_ck_ended    <= 1'b0;
            r_hex_value   <= '0;
            r_hex_stopped <= 1'b0;
        end else if (i_accept) begin
            r_at_start    <= n_at_start;
            r_xor_acc     <= n_xor_acc;
            r_xor_stopped <= n_xor_stopped;
            r_sep_count   <= n_sep_count;
            r_comma_count <= n_comma_count;
            r_star_seen   <= n_star_seen;
            r_sel_ended   <= n_sel_ended;
            r_ck_len      <= n_ck_len;
            r_ck_ended    <= n_ck_ended;
            r_hex_value   <= n_hex_value;
            r_hex_stopped <= n_hex_stopped;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nmea_sc_outbuf.sv =====
// ============================================================================
// NMEA sentence checker output buffer
// Result register with a skid entry, so a new beat is taken while the
// previous result waits downstream.
// ============================================================================
`default_nettype none

module nmea_sc_outbuf (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire nmea_sc_pkg::t_result i_result,
    output logic                      o_ready,
    output logic                      o_valid,
    input  wire logic                 i_taken,
    output nmea_sc_pkg::t_result      o_result
);
    import nmea_sc_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop      = r_out_valid && i_taken;
    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Payload: refill from skid on a pop, else load the new beat
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nmea_sentence_checker.sv =====
// ============================================================================
// NMEA sentence checker
// Checksum check and field extraction for NMEA sentences, one character
// per beat.
// ============================================================================
// Characters enter one per beat on i_char, the first being the start mark
// that is skipped; last marks the final character. Every input beat gives
// exactly one result beat, held in the output buffer: the character itself if it lies
// in the selected field, and on the last character the XOR checksum, the
// comma count and the verdict (good, bad, or absent). One character is
// taken every cycle; the whole step is a single combinational pass between
// the sentence state registers and a result register backed by one skid
// entry, so i_char.ready drops only when both are full. Configuration
// writes on i_cfg are always taken and apply from the next character on.
`default_nettype none

module nmea_sentence_checker (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    nmea_char_if.sink   i_char,
    nmea_cfg_if.sink    i_cfg,
    nmea_res_if.source  o_res
);
    import nmea_sc_pkg::*;

    t_cfg    r_cfg;
    t_result step_result;
    t_result buf_result;
    logic    in_accept;
    logic    buf_ready;

    assign i_cfg.ready  = 1'b1;
    assign i_char.ready = buf_ready;
    assign in_accept    = i_char.valid && buf_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_SELECTED_FIELD: r_cfg.selected_field <= i_cfg.wr_data;
                REG_CHECKSUM_FIELD: r_cfg.checksum_field <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    nmea_sc_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_char_in (i_char.char_in),
        .i_last    (i_char.last),
        .i_cfg     (r_cfg),
        .o_result  (step_result)
    );

    nmea_sc_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_result (step_result),
        .o_ready  (buf_ready),
        .o_valid  (o_res.valid),
        .i_taken  (o_res.ready),
        .o_result (buf_result)
    );

    // Drive the result channel
    assign o_res.field_char_valid = buf_result.field_char_valid;
    assign o_res.field_char       = buf_result.field_char;
    assign o_res.done_res         = buf_result.done_res;
    assign o_res.checksum         = buf_result.checksum;
    assign o_res.data_field_count = buf_result.data_field_count;
    assign o_res.verdict          = buf_result.verdict;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ============================================================================
// NMEA sentence checker testbench
// Streams sentences through the checker one character per beat and compares
// every result beat with a cycle-free model of the field, checksum and verdict
// logic kept in a small scoreboard. Directed sentences first, then random
// well-formed, broken and noise sentences under several field settings, with
// random gaps on both channels and one long output hold-off.
// ============================================================================

module testbench;
    import nmea_sc_pkg::*;

    localparam int N_PHASES     = 10;
    localparam int PHASE_ITEMS  = 108;
    localparam int HOLD_CYCLES  = 150;
    localparam int QUIET_LIMIT  = 3000;
    localparam int RES_LATENCY  = 2;

    localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CHAR_W-1:0] CH_PERIOD  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DIGIT0  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

    // ------------------------------------------------------------------------
    // Scoreboard: sentence state model plus the queue of predicted beats
    // ------------------------------------------------------------------------
    class sentence_book;
        logic [FIELD_W-1:0] sel_field;
        logic [FIELD_W-1:0] ck_field;
        bit                 at_start;
        bit                 xor_stopped;
        bit                 star_seen;
        bit                 select_ended;
        bit                 ck_ended;
        bit                 hex_stopped;
        logic [CHAR_W-1:0]  xor_acc;
        logic [FIELD_W-1:0] sep_count;
        logic [FIELD_W-1:0] comma_count;
        logic [1:0]         ck_len;
        logic [HEX_W-1:0]   hex_val;
        t_result            predicted_beats[$];
        int                 n_chars;
        int                 n_sentences;
        int                 n_checked;
        int                 n_field_chars;
        int                 n_errors;
        int                 n_verdict[3];

        function new();
            sel_field = '0;
            ck_field  = '0;
            restart();
        endfunction

        function void restart();
            at_start     = 1'b1;
            xor_stopped  = 1'b0;
            star_seen    = 1'b0;
            select_ended = 1'b0;
            ck_ended     = 1'b0;
            hex_stopped  = 1'b0;
            xor_acc      = '0;
            sep_count    = '0;
            comma_count  = '0;
            ck_len       = '0;
            hex_val      = '0;
        endfunction

        function void set_field(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
            if (idx == REG_SELECTED_FIELD) sel_field = val;
            else if (idx == REG_CHECKSUM_FIELD) ck_field = val;
        endfunction

        // Append one character to the checksum text; the first one is dropped
        function void take_ck_char(input logic [CHAR_W-1:0] c);
            int digit;
            int wide;
            if (ck_len == 2'd0) begin
                ck_len = 2'd1;
                return;
            end
            ck_len = 2'd2;
            if (hex_stopped) return;
            if (c >= CH_DIGIT0 && c <= CH_DIGIT0 + 8'd9) begin
                digit = int'(c - CH_DIGIT0);
            end else if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) begin
                digit = int'(c - CH_UPPER_A) + 10;
            end else if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) begin
                digit = int'(c - CH_LOWER_A) + 10;
            end else begin
                hex_stopped = 1'b1;
                return;
            end
            wide = int'(hex_val[7:0]) * 16 + digit;
            if (hex_val[8] || wide > 255) hex_val = {1'b1, 8'(wide)};
            else hex_val = 9'(wide);
        endfunction

        // Advance the sentence state by one character and form its result beat
        function t_result parse_char(input logic [CHAR_W-1:0] c, input logic lst);
            t_result r;
            logic    is_sep;
            logic    is_end;
            r = '0;
            if (at_start) begin
                at_start = 1'b0;
            end else begin
                is_sep = (c == CH_COMMA) || (c == CH_STAR);
                is_end = is_sep || (c == CH_NUL);
                if (!xor_stopped) begin
                    if (c == CH_STAR || c == CH_CR || c == CH_LF) xor_stopped = 1'b1;
                    else xor_acc ^= c;
                end
                if (!star_seen) begin
                    if (c == CH_STAR) star_seen = 1'b1;
                    else if (c == CH_COMMA && comma_count < SAT_COUNT) comma_count++;
                end
                if (!select_ended && sep_count == sel_field) begin
                    if (is_end) begin
                        select_ended = 1'b1;
                    end else begin
                        r.field_char_valid = 1'b1;
                        r.field_char       = c;
                    end
                end
                if (!ck_ended) begin
                    if (sep_count == ck_field) begin
                        if (is_end) ck_ended = 1'b1;
                        else take_ck_char(c);
                    end else if (sep_count < ck_field && c == CH_STAR) begin
                        take_ck_char(c);
                    end
                end
                if (is_sep && sep_count < SAT_COUNT) sep_count++;
            end
            if (lst) begin
                r.done_res         = 1'b1;
                r.checksum         = xor_acc;
                r.data_field_count = comma_count;
                if (ck_len == 2'd0) r.verdict = VERDICT_ABSENT;
                else if (hex_val == {1'b0, xor_acc}) r.verdict = VERDICT_GOOD;
                else r.verdict = VERDICT_BAD;
                restart();
            end
            return r;
        endfunction

        function void note_char(input logic [CHAR_W-1:0] c, input logic lst);
            t_result r;
            r = parse_char(c, lst);
            n_chars++;
            if (r.field_char_valid) n_field_chars++;
            if (r.done_res) begin
                n_sentences++;
                n_verdict[r.verdict]++;
            end
            predicted_beats.push_back(r);
        endfunction

        function int pending();
            return predicted_beats.size();
        endfunction

        task report(input string msg);
            n_errors++;
            if (n_errors <= 60) $display("testbench: mismatch on beat %0d: %s", n_checked, msg);
        endtask

        task check_result(input logic fcv, input logic [CHAR_W-1:0] fc, input logic done,
                          input logic [CHAR_W-1:0] sum, input logic [FIELD_W-1:0] cnt,
                          input logic [VERDICT_W-1:0] vd);
            t_result w;
            if (predicted_beats.size() == 0) begin
                report("result beat with no character pending");
                return;
            end
            w = predicted_beats.pop_front();
            n_checked++;
            if (fcv !== w.field_char_valid)
                report($sformatf("field_char_valid got %b want %b", fcv, w.field_char_valid));
            if (fc !== w.field_char)
                report($sformatf("field_char got %02h want %02h", fc, w.field_char));
            if (done !== w.done_res)
                report($sformatf("done_res got %b want %b", done, w.done_res));
            if (sum !== w.checksum)
                report($sformatf("checksum got %02h want %02h", sum, w.checksum));
            if (cnt !== w.data_field_count)
                report($sformatf("data_field_count got %0d want %0d", cnt, w.data_field_count));
            if (vd !== w.verdict)
                report($sformatf("verdict got %0d want %0d", vd, w.verdict));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    nmea_char_if char_if();
    nmea_res_if  res_if();
    nmea_cfg_if  cfg_if();

    nmea_sentence_checker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sentence_book book = new();

    logic [CHAR_W-1:0] sentence_q[$];
    logic [CHAR_W-1:0] line_xor;
    bit                tx_steady;
    bit                rx_steady;
    bit                hold_req;
    int                n_holds;
    int                quiet_cycles;

    int phase_sel [N_PHASES] = '{0, 63, 1, 3, 2, 0, 5, -1, -1, 4};
    int phase_ck  [N_PHASES] = '{0, 63, 4, 2, 7, 1, 3, -1, -1, 6};

    // ------------------------------------------------------------------------
    // Sentence builders
    // ------------------------------------------------------------------------
    // Mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else return $urandom_range(20, 48);
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib, input bit lower);
        if (nib < 4'd10) return CH_DIGIT0 + 8'(nib);
        return (lower ? CH_LOWER_A : CH_UPPER_A) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [CHAR_W-1:0] noise_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(0, 255));
            3, 4, 5: return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            6:       return CH_COMMA;
            7:       return CH_STAR;
            8:       return $urandom_range(0, 1) ? CH_NUL : CH_DOLLAR;
            default: return $urandom_range(0, 1) ? CH_CR : CH_LF;
        endcase
    endfunction

    function automatic void put_body(input logic [CHAR_W-1:0] c);
        sentence_q.push_back(c);
        line_xor ^= c;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) sentence_q.push_back(s[i]);
    endfunction

    // Well-formed sentence: start mark, talker, fields, star, hex sum, mostly CR LF
    function automatic void build_good(input int n_commas, input int max_len);
        logic [CHAR_W-1:0] sum;
        int                style;
        int                k;
        int                r;
        sentence_q.delete();
        line_xor = '0;
        sentence_q.push_back(CH_DOLLAR);
        repeat (5) put_body(CH_UPPER_A + 8'($urandom_range(0, 25)));
        for (int i = 0; i < n_commas; i++) begin
            put_body(CH_COMMA);
            k = $urandom_range(0, max_len);
            for (int j = 0; j < k; j++) begin
                r = $urandom_range(0, 36);
                if (r < 10) put_body(CH_DIGIT0 + 8'(r));
                else if (r < 36) put_body(CH_UPPER_A + 8'(r - 10));
                else put_body(CH_PERIOD);
            end
        end
        sentence_q.push_back(CH_STAR);
        // mostly a correct sum; sometimes lower case, wrong, or three digits
        style = $urandom_range(0, 9);
        sum = (style == 8) ? line_xor ^ 8'($urandom_range(1, 255)) : line_xor;
        if (style == 9) sentence_q.push_back(hex_char(4'($urandom_range(1, 15)), 1'b0));
        sentence_q.push_back(hex_char(sum[7:4], style == 7));
        sentence_q.push_back(hex_char(sum[3:0], style == 7));
        if ($urandom_range(0, 9) < 7) begin
            sentence_q.push_back(CH_CR);
            sentence_q.push_back(CH_LF);
        end
    endfunction

    // Pick a sentence shape: mostly well-formed, some broken, some noise
    function automatic void make_sentence(input int ck);
        int kind;
        int n;
        int pos;
        kind = $urandom_range(0, 99);
        if (ck >= 1 && $urandom_range(0, 4) != 0) n = ck - 1;
        else n = $urandom_range(0, 8);
        if ($urandom_range(0, 39) == 0) n = $urandom_range(64, 70);
        if (kind < 15) begin
            sentence_q.delete();
            repeat ($urandom_range(1, 16)) sentence_q.push_back(noise_char());
        end else begin
            build_good(n, (n > 20) ? 1 : 6);
            if (kind < 30) begin
                pos = $urandom_range(0, sentence_q.size() - 1);
                if ($urandom_range(0, 1)) sentence_q[pos] = noise_char();
                else while (sentence_q.size() > pos + 1) void'(sentence_q.pop_back());
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic lst);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        char_if.valid   <= 1'b1;
        char_if.char_in <= c;
        char_if.last    <= lst;
        do begin
            @(posedge i_clk);
        end while (!char_if.ready);
        book.note_char(c, lst);
        // hold valid when the next beat follows at once
        if (gap > 0) begin
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_sentence();
        for (int i = 0; i < sentence_q.size(); i++)
            send_char(sentence_q[i], i == sentence_q.size() - 1);
    endtask

    // Wait until every predicted beat has come out
    task automatic drain();
        char_if.valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (RES_LATENCY) @(posedge i_clk);
    endtask

    task automatic load_fields(input logic [FIELD_W-1:0] sel, input logic [FIELD_W-1:0] ck);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= REG_SELECTED_FIELD;
        cfg_if.wr_data   <= sel;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        book.set_field(REG_SELECTED_FIELD, sel);
        cfg_if.reg_index <= REG_CHECKSUM_FIELD;
        cfg_if.wr_data   <= ck;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        book.set_field(REG_CHECKSUM_FIELD, ck);
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left   = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready)
                book.check_result(res_if.field_char_valid, res_if.field_char, res_if.done_res,
                                  res_if.checksum, res_if.data_field_count, res_if.verdict);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
                n_holds++;
            end else if (stall_left == 0 && !rx_steady && $urandom_range(0, 2) == 0) begin
                stall_left = idle_len();
            end
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run after a long stretch with no beat anywhere
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((char_if.valid && char_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("testbench: no progress for %0d cycles", QUIET_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int sel_v;
        int ck_v;
        int start_n;
        i_rst_n          = 1'b0;
        char_if.valid    = 1'b0;
        char_if.char_in  = '0;
        char_if.last     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.reg_index = REG_SELECTED_FIELD;
        cfg_if.wr_data   = '0;
        tx_steady        = 1'b0;
        rx_steady        = 1'b0;
        hold_req         = 1'b0;
        n_holds          = 0;
        quiet_cycles     = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sentences with field 1 streamed and field 2 as checksum
        load_fields(6'd1, 6'd2);
        // start mark that is also the last character
        sentence_q.delete();
        sentence_q.push_back(CH_DOLLAR);
        send_sentence();
        // NUL ends the selected field early; lower case checksum digits
        sentence_q.delete();
        push_text("$A,b");
        sentence_q.push_back(CH_NUL);
        push_text("c*7f");
        send_sentence();
        // star ahead of the selected field; one-character checksum text
        sentence_q.delete();
        push_text("$Q*1");
        sentence_q.push_back(8'hFF);
        send_sentence();
        // checksum value above 255, parse stops at a non-hex character
        sentence_q.delete();
        push_text("$,*1FF");
        sentence_q.push_back(8'h80);
        send_sentence();
        // no checksum text at all
        sentence_q.delete();
        push_text("$,E");
        send_sentence();

        // Random phases under different field settings
        for (int p = 0; p < N_PHASES; p++) begin
            sel_v = (phase_sel[p] < 0) ? $urandom_range(0, 63) : phase_sel[p];
            ck_v  = (phase_ck[p] < 0) ? $urandom_range(0, 12) : phase_ck[p];
            drain();
            load_fields(6'(sel_v), 6'(ck_v));
            tx_steady = (p == 3);
            rx_steady = (p == 3 || p == 7);
            start_n   = book.n_chars;
            if (p == 5) begin
                // block the output while characters keep coming back to back
                hold_req  = 1'b1;
                tx_steady = 1'b1;
                build_good(5, 6);
                send_sentence();
                tx_steady = 1'b0;
                drain();
            end
            while (book.n_chars - start_n < PHASE_ITEMS) begin
                make_sentence(ck_v);
                send_sentence();
            end
        end

        drain();
        $display("testbench: %0d characters in %0d sentences, %0d beats checked, %0d field chars",
                 book.n_chars, book.n_sentences, book.n_checked, book.n_field_chars);
        $display("testbench: verdicts good %0d bad %0d absent %0d, %0d long output hold-offs",
                 book.n_verdict[VERDICT_GOOD], book.n_verdict[VERDICT_BAD],
                 book.n_verdict[VERDICT_ABSENT], n_holds);
        if (book.n_errors == 0 && book.pending() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
